/* src/spectral_gate_noise_reducer_macros.svh */
// Assertion macros for the spectral gate noise reducer
`ifndef SPECTRAL_GATE_NOISE_REDUCER_MACROS_SVH
`define SPECTRAL_GATE_NOISE_REDUCER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SGNR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SGNR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sgnr_pkg.sv */
// Shared types, constants and helpers for the spectral gate noise reducer
`timescale 1ns / 1ps
package sgnr_pkg;

    localparam int unsigned DefMaxBins = 64;
    localparam int unsigned CfgAddrW   = 3;
    localparam int unsigned CfgDataW   = 13;
    localparam int unsigned MagW       = 16;
    localparam int unsigned Q12W       = 13;
    localparam int unsigned BinCntW    = 7;
    localparam int unsigned FloorW     = 32;

    localparam logic [Q12W-1:0] OneQ12   = 13'd4096;
    localparam logic [Q12W-1:0] RateFast = 13'd5243;
    localparam logic [Q12W-1:0] RateSlow = 13'd983;

    localparam logic [CfgAddrW-1:0] CFG_GATE_OFFSET = 3'd0;
    localparam logic [CfgAddrW-1:0] CFG_ATTENUATION = 3'd1;
    localparam logic [CfgAddrW-1:0] CFG_SMOOTHING   = 3'd2;
    localparam logic [CfgAddrW-1:0] CFG_FAST_TRACK  = 3'd3;
    localparam logic [CfgAddrW-1:0] CFG_BIN_COUNT   = 3'd4;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SELECT,
        ST_PREP,
        ST_READ,
        ST_MUL,
        ST_GATE,
        ST_CMP,
        ST_SMUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic insert;
        logic sort_clr;
        logic shift;
        logic prep;
        logic rd;
        logic mul;
        logic gate;
        logic cmp;
        logic smul;
        logic emit;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic [Q12W-1:0] clamp_q12(input logic [Q12W-1:0] v);
        return (v > OneQ12) ? OneQ12 : v;
    endfunction

    // n / 5 for n below 128
    function automatic logic [4:0] div5(input logic [BinCntW-1:0] n);
        logic [14:0] p;
        p = 15'(n) * 15'd205;
        return p[14:10];
    endfunction

endpackage

/* src/sgnr_ctrl.sv */
// Controller state machine: frame loading, noise selection and per-bin sequencing
`timescale 1ns / 1ps
`include "spectral_gate_noise_reducer_macros.svh"
module sgnr_ctrl #(
    parameter int unsigned MAX_BINS = sgnr_pkg::DefMaxBins,
    parameter int unsigned AW = $clog2(MAX_BINS),
    parameter int unsigned CW = $clog2(MAX_BINS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr,
    input  logic [CW-1:0]         i_bin_count,
    input  logic                  i_bin_valid,
    output logic                  o_bin_ready,
    input  sgnr_pkg::t_dp_status  i_status,
    output sgnr_pkg::t_dp_cmd     o_cmd,
    output logic [AW-1:0]         o_addr
);

    sgnr_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_load_cnt, n_load_cnt;
    logic [AW-1:0] r_idx, n_idx;
    logic [4:0]    r_k, n_k;
    logic [CW-1:0] load_inc;
    logic [CW-1:0] idx_inc;
    logic          accept;

    assign load_inc = CW'(r_load_cnt + 1'b1);
    assign idx_inc  = CW'(r_idx) + CW'(1);
    assign accept   = i_bin_valid && o_bin_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_state    <= sgnr_pkg::ST_LOAD;
            r_load_cnt <= '0;
            r_idx      <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_idx      <= n_idx;
            r_k        <= n_k;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_idx       = r_idx;
        n_k         = r_k;
        o_cmd       = '0;
        o_bin_ready = 1'b0;
        o_addr      = r_idx;
        case (r_state)
            sgnr_pkg::ST_LOAD: begin
                o_bin_ready = !i_clr;
                o_addr      = r_load_cnt[AW-1:0];
                if (accept) begin
                    o_cmd.insert = 1'b1;
                    if (load_inc == i_bin_count) begin
                        n_load_cnt = '0;
                        n_k        = sgnr_pkg::div5(sgnr_pkg::BinCntW'(i_bin_count));
                        n_state    = sgnr_pkg::ST_SELECT;
                    end else begin
                        n_load_cnt = load_inc;
                    end
                end
            end
            sgnr_pkg::ST_SELECT: begin
                if (r_k == '0) begin
                    n_state = sgnr_pkg::ST_PREP;
                end else begin
                    o_cmd.shift = 1'b1;
                    n_k         = r_k - 5'd1;
                end
            end
            sgnr_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_idx      = '0;
                n_state    = sgnr_pkg::ST_READ;
            end
            sgnr_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = sgnr_pkg::ST_MUL;
            end
            sgnr_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = sgnr_pkg::ST_GATE;
            end
            sgnr_pkg::ST_GATE: begin
                o_cmd.gate = 1'b1;
                n_state    = sgnr_pkg::ST_CMP;
            end
            sgnr_pkg::ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = sgnr_pkg::ST_SMUL;
            end
            sgnr_pkg::ST_SMUL: begin
                o_cmd.smul = 1'b1;
                n_state    = sgnr_pkg::ST_EMIT;
            end
            sgnr_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (idx_inc == i_bin_count);
                    if (idx_inc == i_bin_count) begin
                        o_cmd.sort_clr = 1'b1;
                        n_state        = sgnr_pkg::ST_LOAD;
                    end else begin
                        n_idx   = AW'(idx_inc);
                        n_state = sgnr_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = sgnr_pkg::ST_LOAD;
            end
        endcase
    end

    `SGNR_ASSERT_IMP(a_emit_free, o_cmd.emit, i_status.out_free, "emit while output busy")
    `SGNR_ASSERT_IMP(a_load_bound, r_state == sgnr_pkg::ST_LOAD, r_load_cnt < i_bin_count,
        "load count reached bin count")
    `SGNR_ASSERT_NXT(a_frame_select, accept && !i_clr && load_inc == i_bin_count,
        r_state == sgnr_pkg::ST_SELECT, "full frame did not start selection")

endmodule

/* src/sgnr_datapath.sv */
// Datapath: frame and history memories, insertion sorter, floor, gate and smoothing math
`timescale 1ns / 1ps
`include "spectral_gate_noise_reducer_macros.svh"
module sgnr_datapath #(
    parameter int unsigned MAX_BINS = sgnr_pkg::DefMaxBins,
    parameter int unsigned AW = $clog2(MAX_BINS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  sgnr_pkg::t_dp_cmd             i_cmd,
    output sgnr_pkg::t_dp_status          o_status,
    input  logic [AW-1:0]                 i_addr,
    input  logic [sgnr_pkg::MagW-1:0]     i_bin_magnitude,
    input  logic [sgnr_pkg::Q12W-1:0]     i_rate,
    input  logic [sgnr_pkg::Q12W-1:0]     i_thr,
    input  logic [sgnr_pkg::Q12W-1:0]     i_keep,
    input  logic [sgnr_pkg::Q12W-1:0]     i_weight,
    output logic                          o_clean_valid,
    input  logic                          i_clean_ready,
    output logic [sgnr_pkg::MagW-1:0]     o_clean_magnitude,
    output logic                          o_frame_end
);

    localparam int unsigned MW = sgnr_pkg::MagW;
    localparam int unsigned FW = sgnr_pkg::FloorW;

    logic [MW-1:0] mem_frame [MAX_BINS];
    logic [FW-1:0] mem_floor [MAX_BINS];
    logic [MW-1:0] mem_last  [MAX_BINS];
    logic [MAX_BINS-1:0] r_fv;
    logic [MAX_BINS-1:0] r_lv;

    logic [MW-1:0] r_sort [MAX_BINS];
    logic [MAX_BINS-1:0] r_sv;
    logic [MAX_BINS-1:0] lt;

    logic [MW-1:0] r_noise;
    logic [28:0]   r_rn;
    logic [MW-1:0] r_mag;
    logic [FW-1:0] r_floor_q;
    logic          r_fvq;
    logic [MW-1:0] r_last_raw;
    logic          r_lvq;
    logic [48:0]   r_p1;
    logic [28:0]   r_pg;
    logic [FW-1:0] r_fl_new;
    logic [MW-1:0] r_gated;
    logic [28:0]   r_s1;
    logic [28:0]   r_s2;
    logic [MW-1:0] r_out_mag;
    logic          r_out_last;
    logic          r_out_valid;

    logic [16:0]   one_m_rate;
    logic [FW-1:0] fl_sel;
    logic [49:0]   fl_sum;
    logic [32:0]   thr_sum;
    logic [32:0]   mag_sh;
    logic [MW-1:0] last_q;
    logic [29:0]   sm_sum;
    logic [17:0]   sm;
    logic [MW-1:0] sm_sat;

    assign o_status.out_free = !r_out_valid || i_clean_ready;

    // Insertion sorter: cells keep, take new value or left neighbor, or shift from the right
    always_comb begin
        for (int i = 0; i < MAX_BINS; i++) begin
            lt[i] = r_sv[i] && (r_sort[i] <= i_bin_magnitude);
        end
    end

    for (genvar gi = 0; gi < MAX_BINS; gi++) begin : g_sort
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_clr || i_cmd.sort_clr) begin
                r_sv[gi] <= 1'b0;
            end else if (i_cmd.insert && !lt[gi]) begin
                if (gi == 0) begin
                    r_sv[gi] <= 1'b1;
                end else begin
                    r_sv[gi] <= lt[(gi == 0) ? 0 : gi - 1] ? 1'b1 : r_sv[(gi == 0) ? 0 : gi - 1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.insert && !lt[gi]) begin
                if (gi == 0) begin
                    r_sort[gi] <= i_bin_magnitude;
                end else if (lt[(gi == 0) ? 0 : gi - 1]) begin
                    r_sort[gi] <= i_bin_magnitude;
                end else begin
                    r_sort[gi] <= r_sort[(gi == 0) ? 0 : gi - 1];
                end
            end else if (i_cmd.shift && gi < MAX_BINS - 1) begin
                r_sort[gi] <= r_sort[(gi < MAX_BINS - 1) ? gi + 1 : gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            mem_frame[i_addr] <= i_bin_magnitude;
        end
        if (i_cmd.rd) begin
            r_mag <= mem_frame[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gate) begin
            mem_floor[i_addr] <= fl_sum[47:16];
        end
        if (i_cmd.rd) begin
            r_floor_q <= mem_floor[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            mem_last[i_addr] <= sm_sat;
        end
        if (i_cmd.rd) begin
            r_last_raw <= mem_last[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_fv <= '0;
            r_lv <= '0;
        end else begin
            if (i_cmd.gate) begin
                r_fv[i_addr] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_lv[i_addr] <= 1'b1;
            end
        end
    end

    assign one_m_rate = 17'h10000 - 17'(i_rate);
    assign fl_sel  = (!r_fvq || r_floor_q == '0) ? {r_noise, 16'b0} : r_floor_q;
    assign fl_sum  = 50'(r_p1) + {5'b0, r_rn, 16'b0};
    assign thr_sum = {1'b0, r_fl_new} + {4'b0, i_thr, 16'b0};
    assign mag_sh  = {1'b0, r_mag, 16'b0};
    assign last_q  = r_lvq ? r_last_raw : '0;
    assign sm_sum  = 30'(r_s1) + 30'(r_s2);
    assign sm      = sm_sum[29:12];
    assign sm_sat  = (sm > 18'(16'hFFFF)) ? 16'hFFFF : sm[MW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_noise <= r_sort[0];
            r_rn    <= i_rate * r_sort[0];
        end
        if (i_cmd.rd) begin
            r_fvq <= r_fv[i_addr];
            r_lvq <= r_lv[i_addr];
        end
        if (i_cmd.mul) begin
            r_p1 <= one_m_rate * fl_sel;
            r_pg <= r_mag * i_keep;
        end
        if (i_cmd.gate) begin
            r_fl_new <= fl_sum[47:16];
        end
        if (i_cmd.cmp) begin
            r_gated <= (mag_sh < thr_sum) ? r_pg[27:12] : r_mag;
        end
        if (i_cmd.smul) begin
            r_s1 <= i_weight * last_q;
            r_s2 <= (sgnr_pkg::OneQ12 - i_weight) * r_gated;
        end
        if (i_cmd.emit) begin
            r_out_mag  <= sm_sat;
            r_out_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_clean_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_clean_valid     = r_out_valid;
    assign o_clean_magnitude = r_out_mag;
    assign o_frame_end       = r_out_last;

    `SGNR_ASSERT_IMP(a_sort_order, r_sv[1], r_sort[0] <= r_sort[1], "sorter out of order")
    `SGNR_ASSERT_NXT(a_emit_valid, i_cmd.emit, r_out_valid, "emitted result not presented")

endmodule

/* src/spectral_gate_noise_reducer.sv */
// After the last bin of a frame, the sorter shifts to sorted index bin_count/5 for the noise
// estimate and a setup step loads it; each bin then runs the read, multiply, gate, compare,
// smoothing-multiply and emit steps of the single shared floor, gate and smoothing datapath,
// emit waiting while the output is full. No new bins are taken until the frame's last is emitted.
// Reset (synchronous, active low) and any bin_count write clear the per-bin floor
// and last-output history and drop a partly loaded frame; no clearing pass is needed.
`timescale 1ns / 1ps
module spectral_gate_noise_reducer #(
    parameter int unsigned MAX_BINS = sgnr_pkg::DefMaxBins
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sgnr_pkg::CfgAddrW-1:0]     i_cfg_addr,
    input  logic [sgnr_pkg::CfgDataW-1:0]     i_cfg_wdata,
    input  logic                              i_bin_valid,
    output logic                              o_bin_ready,
    input  logic [sgnr_pkg::MagW-1:0]         i_bin_magnitude,
    output logic                              o_clean_valid,
    input  logic                              i_clean_ready,
    output logic [sgnr_pkg::MagW-1:0]         o_clean_magnitude,
    output logic                              o_frame_end
);

    localparam int unsigned AW = $clog2(MAX_BINS);
    localparam int unsigned CW = $clog2(MAX_BINS + 1);
    localparam int unsigned QW = sgnr_pkg::Q12W;
    localparam int unsigned BW = sgnr_pkg::BinCntW;

    logic [QW-1:0] r_gate_offset;
    logic [QW-1:0] r_attenuation;
    logic [QW-1:0] r_smoothing;
    logic          r_fast;
    logic [CW-1:0] r_bin_count;
    logic          clr;
    logic [BW-1:0] bc_raw;
    logic [CW-1:0] bc_clamped;

    sgnr_pkg::t_dp_cmd    cmd;
    sgnr_pkg::t_dp_status status;
    logic [AW-1:0]        addr;

    assign clr    = i_cfg_we && i_cfg_addr == sgnr_pkg::CFG_BIN_COUNT;
    assign bc_raw = i_cfg_wdata[BW-1:0];
    assign bc_clamped = (bc_raw == '0) ? CW'(1) :
                        (bc_raw > BW'(MAX_BINS)) ? CW'(MAX_BINS) : CW'(bc_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_offset <= '0;
            r_attenuation <= '0;
            r_smoothing   <= '0;
            r_fast        <= 1'b0;
            r_bin_count   <= CW'(MAX_BINS);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sgnr_pkg::CFG_GATE_OFFSET: r_gate_offset <= i_cfg_wdata;
                sgnr_pkg::CFG_ATTENUATION: r_attenuation <= i_cfg_wdata;
                sgnr_pkg::CFG_SMOOTHING:   r_smoothing   <= i_cfg_wdata;
                sgnr_pkg::CFG_FAST_TRACK:  r_fast        <= i_cfg_wdata[0];
                sgnr_pkg::CFG_BIN_COUNT:   r_bin_count   <= bc_clamped;
                default: begin
                end
            endcase
        end
    end

    sgnr_ctrl #(
        .MAX_BINS (MAX_BINS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (clr),
        .i_bin_count (r_bin_count),
        .i_bin_valid (i_bin_valid),
        .o_bin_ready (o_bin_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    sgnr_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_clr             (clr),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_addr            (addr),
        .i_bin_magnitude   (i_bin_magnitude),
        .i_rate            (r_fast ? sgnr_pkg::RateFast : sgnr_pkg::RateSlow),
        .i_thr             (sgnr_pkg::clamp_q12(r_gate_offset)),
        .i_keep            (sgnr_pkg::OneQ12 - sgnr_pkg::clamp_q12(r_attenuation)),
        .i_weight          (sgnr_pkg::clamp_q12(r_smoothing)),
        .o_clean_valid     (o_clean_valid),
        .i_clean_ready     (i_clean_ready),
        .o_clean_magnitude (o_clean_magnitude),
        .o_frame_end       (o_frame_end)
    );

endmodule

/* bench/sgnr_checker.sv */
// Checker for the spectral gate noise reducer: predicts each frame and compares the outputs
`timescale 1ns / 1ps
module sgnr_checker
    import sgnr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    input  logic                i_bin_valid,
    input  logic                i_bin_ready,
    input  logic [MagW-1:0]     i_bin_magnitude,
    input  logic                i_clean_valid,
    input  logic                i_clean_ready,
    input  logic [MagW-1:0]     i_clean_magnitude,
    input  logic                i_frame_end,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_frames,
    output int                  o_results
);

    localparam int unsigned NumBins = DefMaxBins;

    typedef struct {
        logic [MagW-1:0] mag;
        logic            last;
    } t_clean_bin;

    t_clean_bin      clean_q[$];
    logic [Q12W-1:0] thr_reg;
    logic [Q12W-1:0] atten_reg;
    logic [Q12W-1:0] weight_reg;
    logic            fast_reg;
    logic [6:0]      nbins;
    logic [MagW-1:0] frame_bins[NumBins];
    logic [31:0]     floor_q28[NumBins];
    logic [MagW-1:0] prev_out[NumBins];
    int              loaded;
    int              errors;
    int              frames;
    int              results;

    assign o_errors  = errors;
    assign o_pending = clean_q.size();
    assign o_frames  = frames;
    assign o_results = results;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [63:0] sat_q12(input logic [Q12W-1:0] v);
        return (v > 13'd4096) ? 64'd4096 : 64'(v);
    endfunction

    task automatic clear_history();
        for (int i = 0; i < NumBins; i++) begin
            floor_q28[i] = '0;
            prev_out[i]  = '0;
        end
        loaded = 0;
    endtask

    task automatic gate_frame();
        logic [MagW-1:0] sorted[NumBins];
        logic [MagW-1:0] v;
        logic [63:0]     noise_q28, fl, mag, gated, sm, keep, w, rate, gate_add;
        int              j;
        for (int i = 0; i < nbins; i++) begin
            v = frame_bins[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        noise_q28 = 64'(sorted[nbins / 5]) << 16;
        rate      = fast_reg ? 64'd5243 : 64'd983;
        keep      = 64'd4096 - sat_q12(atten_reg);
        w         = sat_q12(weight_reg);
        gate_add  = sat_q12(thr_reg) << 16;
        for (int i = 0; i < nbins; i++) begin
            fl  = 64'(floor_q28[i]);
            mag = 64'(frame_bins[i]);
            if (fl == 0) fl = noise_q28;
            fl = ((64'd65536 - rate) * fl + rate * noise_q28) >> 16;
            floor_q28[i] = fl[31:0];
            fl = 64'(floor_q28[i]);
            if ((mag << 16) < fl + gate_add) gated = (mag * keep) >> 12;
            else gated = mag;
            sm = (w * 64'(prev_out[i]) + (64'd4096 - w) * gated) >> 12;
            if (sm > 64'hFFFF) sm = 64'hFFFF;
            prev_out[i] = sm[15:0];
            clean_q.push_back('{mag: sm[15:0], last: (i + 1 == nbins)});
        end
        frames++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_reg    = '0;
            atten_reg  = '0;
            weight_reg = '0;
            fast_reg   = 1'b0;
            nbins      = 7'(NumBins);
            clear_history();
            clean_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GATE_OFFSET: thr_reg = i_cfg_wdata;
                    CFG_ATTENUATION: atten_reg = i_cfg_wdata;
                    CFG_SMOOTHING:   weight_reg = i_cfg_wdata;
                    CFG_FAST_TRACK:  fast_reg = i_cfg_wdata[0];
                    CFG_BIN_COUNT: begin
                        nbins = i_cfg_wdata[6:0];
                        if (nbins == 0) nbins = 7'd1;
                        if (nbins > NumBins) nbins = 7'(NumBins);
                        clear_history();
                    end
                    default: ;
                endcase
            end
            if (i_bin_valid && i_bin_ready) begin
                if (loaded >= nbins) loaded = 0;
                frame_bins[loaded] = i_bin_magnitude;
                loaded++;
                if (loaded >= nbins) begin
                    loaded = 0;
                    gate_frame();
                end
            end
            if (i_clean_valid && i_clean_ready) begin
                results++;
                if (clean_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction mag=%0d end=%0b",
                                              i_clean_magnitude, i_frame_end));
                end else begin
                    if (i_clean_magnitude !== clean_q[0].mag)
                        report_mismatch($sformatf("clean_magnitude %0d, want %0d",
                                                  i_clean_magnitude, clean_q[0].mag));
                    if (i_frame_end !== clean_q[0].last)
                        report_mismatch($sformatf("frame_end %0b, want %0b",
                                                  i_frame_end, clean_q[0].last));
                    void'(clean_q.pop_front());
                end
            end
        end
    end

    initial begin
        errors  = 0;
        frames  = 0;
        results = 0;
    end

endmodule

/* bench/spectral_gate_noise_reducer_tb.sv */
// Testbench top for the spectral gate noise reducer: stimulus, flow control and verdict
`timescale 1ns / 1ps
module spectral_gate_noise_reducer_tb;
    import sgnr_pkg::*;

    localparam int StallLimit = 4000;
    localparam int HoldCycles = 400;

    localparam logic [CfgAddrW-1:0] CfgUnusedLo = 3'd5;
    localparam logic [CfgAddrW-1:0] CfgUnusedHi = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgAddrW-1:0] i_cfg_addr;
    logic [CfgDataW-1:0] i_cfg_wdata;
    logic                i_bin_valid;
    logic                o_bin_ready;
    logic [MagW-1:0]     i_bin_magnitude;
    logic                o_clean_valid;
    logic                i_clean_ready;
    logic [MagW-1:0]     o_clean_magnitude;
    logic                o_frame_end;

    int errors, pending, frames, results;
    int idle_pct, stall_pct;
    int hold_left;
    bit hold_req;
    int quiet_cycles;
    int bins_sent;

    spectral_gate_noise_reducer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_bin_valid      (i_bin_valid),
        .o_bin_ready      (o_bin_ready),
        .i_bin_magnitude  (i_bin_magnitude),
        .o_clean_valid    (o_clean_valid),
        .i_clean_ready    (i_clean_ready),
        .o_clean_magnitude(o_clean_magnitude),
        .o_frame_end      (o_frame_end)
    );

    sgnr_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_bin_valid      (i_bin_valid),
        .i_bin_ready      (o_bin_ready),
        .i_bin_magnitude  (i_bin_magnitude),
        .i_clean_valid    (o_clean_valid),
        .i_clean_ready    (i_clean_ready),
        .i_clean_magnitude(o_clean_magnitude),
        .i_frame_end      (o_frame_end),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_frames         (frames),
        .o_results        (results)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_clean_ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            i_clean_ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            i_clean_ready <= 1'b0;
            hold_req = 1'b0;
            hold_left = HoldCycles;
        end else begin
            i_clean_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_bin_valid && o_bin_ready) || (o_clean_valid && i_clean_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
                $display("timeout after %0d cycles without a transaction", quiet_cycles);
                $display("** spectral_gate_noise_reducer: FAILED **");
                $finish;
            end
        end
    end

    task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        i_bin_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_bin(input logic [MagW-1:0] mag);
        while ($urandom_range(99) < idle_pct) begin
            i_bin_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_bin_valid     <= 1'b1;
        i_bin_magnitude <= mag;
        @(posedge i_clk);
        while (!o_bin_ready) @(posedge i_clk);
        bins_sent++;
    endtask

    function automatic logic [MagW-1:0] rand_mag();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return MagW'($urandom_range(0, 2000));
        if (pick < 85) return MagW'($urandom_range(4096, 40000));
        return MagW'($urandom);
    endfunction

    function automatic logic [CfgDataW-1:0] rand_q12();
        if ($urandom_range(3) == 0) return CfgDataW'($urandom);
        return CfgDataW'($urandom_range(0, 4096));
    endfunction

    task automatic send_frames(input int count);
        for (int i = 0; i < count; i++) send_bin(rand_mag());
    endtask

    task automatic random_config(input logic [6:0] nb);
        cfg_write(CFG_GATE_OFFSET, rand_q12());
        cfg_write(CFG_ATTENUATION, rand_q12());
        cfg_write(CFG_SMOOTHING, rand_q12());
        cfg_write(CFG_FAST_TRACK, CfgDataW'($urandom_range(1)));
        if (nb != 0) cfg_write(CFG_BIN_COUNT, CfgDataW'(nb));
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_wdata     <= '0;
        i_bin_valid     <= 1'b0;
        i_bin_magnitude <= '0;
        hold_req  = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        bins_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, clamping, tiny frames, partial-frame drop
        cfg_write(CFG_BIN_COUNT, 13'd5);
        send_bin(16'd0);
        send_bin(16'hFFFF);
        send_bin(16'd1);
        send_bin(16'h8000);
        send_bin(16'd4096);
        wait_idle();
        cfg_write(CFG_GATE_OFFSET, 13'h1FFF);
        cfg_write(CFG_ATTENUATION, 13'd4096);
        cfg_write(CFG_SMOOTHING, 13'd0);
        cfg_write(CFG_FAST_TRACK, 13'd1);
        send_bin(16'h5555);
        send_bin(16'hAAAA);
        send_bin(16'd100);
        send_bin(16'd200);
        send_bin(16'd300);
        wait_idle();
        cfg_write(CFG_ATTENUATION, 13'h1FFF);
        cfg_write(CFG_SMOOTHING, 13'h1FFF);
        cfg_write(CfgUnusedHi, 13'h1FFF);
        cfg_write(CfgUnusedLo, 13'h0AAA);
        cfg_write(CFG_BIN_COUNT, 13'd0);
        send_bin(16'd7);
        send_bin(16'hFFFF);
        wait_idle();
        cfg_write(CFG_SMOOTHING, 13'd4096);
        cfg_write(CFG_BIN_COUNT, 13'h007F);
        wait_idle();
        cfg_write(CFG_BIN_COUNT, 13'd8);
        send_frames(3);
        wait_idle();
        cfg_write(CFG_SMOOTHING, 13'd2048);
        cfg_write(CFG_FAST_TRACK, 13'd0);
        cfg_write(CFG_BIN_COUNT, 13'd8);
        send_frames(8);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            if (ph == 0) begin
                random_config(7'd8);
                hold_req = 1'b1;
                send_frames(16);
            end else if (ph == 2) begin
                random_config(7'd64);
                send_frames(64);
            end else begin
                random_config(7'($urandom_range(2, 10)));
                send_frames(10);
                wait_idle();
                random_config(7'd0);
                send_frames(4);
            end
            wait_idle();
        end

        idle_pct = 0;
        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d bins in %0d frames across four flow-control phases,",
                 bins_sent, frames);
        $display("checked %0d output bins with %0d mismatches.", results, errors);
        if (errors == 0 && pending == 0) begin
            $display("** spectral_gate_noise_reducer: PASSED **");
        end else begin
            $display("** spectral_gate_noise_reducer: FAILED **");
        end
        $finish;
    end

endmodule
